// ----- sv/pcd_pkg.sv -----
// Types, character constants and the hex digit function of the percent decoder.
package pcd_pkg;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic                         last;
    logic [1:0]                   cnt;
    logic [MAX_RESULTS-1:0][7:0]  data;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t entry;
  } head_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.is_hex = 1'b0;
    r.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.is_hex = 1'b1;
      r.value  = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.is_hex = 1'b1;
      r.value  = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.is_hex = 1'b1;
      r.value  = 4'(c - 8'h57);
    end
    return r;
  endfunction

endpackage

// ----- sv/pcd_front.sv -----
// Front part: accepts raw bytes, tracks the escape state and builds a bundle of decoded bytes.
module pcd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pcd_pkg::in_item_t in_data,
  input  logic              queue_full,
  output logic              in_stall,
  output logic              push,
  output pcd_pkg::bundle_t  bundle
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [7:0]   held_r, held_nxt;
  logic         accept;
  logic         do_fresh;
  logic [1:0]   n;
  pcd_pkg::hex_t hb, hh;
  logic [7:0]   b;

  assign b        = in_data.in_byte;
  assign hb       = pcd_pkg::hex_decode(b);
  assign hh       = pcd_pkg::hex_decode(held_r);
  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    do_fresh    = 1'b0;
    n           = 2'd0;
    bundle.data = '0;
    case (phase_r)
      PH_PCT: begin
        if (hb.is_hex) begin
          held_nxt  = b;
          phase_nxt = PH_DIG;
        end else begin
          bundle.data[0] = pcd_pkg::CHAR_PERCENT;
          n              = 2'd1;
          phase_nxt      = PH_IDLE;
          do_fresh       = 1'b1;
        end
      end
      PH_DIG: begin
        if (hb.is_hex) begin
          bundle.data[0] = {hh.value, hb.value};
          n              = 2'd1;
        end else begin
          bundle.data[0] = pcd_pkg::CHAR_PERCENT;
          bundle.data[1] = held_r;
          n              = 2'd2;
          do_fresh       = 1'b1;
        end
        phase_nxt = PH_IDLE;
        held_nxt  = 8'h00;
      end
      default: begin
        phase_nxt = PH_IDLE;
        do_fresh  = 1'b1;
      end
    endcase
    if (do_fresh) begin
      if (b == pcd_pkg::CHAR_PERCENT) begin
        phase_nxt = PH_PCT;
      end else begin
        bundle.data[n] = (b == pcd_pkg::CHAR_PLUS) ? pcd_pkg::CHAR_SPACE : b;
        n              = 2'(n + 2'd1);
      end
    end
    if (in_data.in_last) begin
      if (phase_nxt == PH_PCT) begin
        bundle.data[n] = pcd_pkg::CHAR_PERCENT;
        n              = 2'(n + 2'd1);
      end else if (phase_nxt == PH_DIG) begin
        bundle.data[n]              = pcd_pkg::CHAR_PERCENT;
        bundle.data[2'(n + 2'd1)]   = held_nxt;
        n                           = 2'(n + 2'd2);
      end
      phase_nxt = PH_IDLE;
      held_nxt  = 8'h00;
    end
    bundle.cnt  = n;
    bundle.last = in_data.in_last;
  end

  assign push = accept && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ----- sv/pcd_fifo.sv -----
// Short queue of decoded-byte bundles between the front and back parts.
module pcd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pcd_pkg::bundle_t wr_entry,
  input  logic             pop,
  output logic             full,
  output pcd_pkg::head_t   head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pcd_pkg::bundle_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= CNT_W'(count_r - 1'b1);
      end
    end
  end

endmodule

// ----- sv/pcd_back.sv -----
// Back part: sends each queued bundle byte by byte and marks the final byte of a last bundle.
module pcd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pcd_pkg::head_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pcd_pkg::out_item_t out_data
);

  logic [1:0] idx_r;
  logic       final_byte;

  assign final_byte        = (idx_r == 2'(head.entry.cnt - 2'd1));
  assign out_valid         = head.valid;
  assign out_data.out_byte = head.entry.data[idx_r];
  assign out_data.out_last = head.entry.last && final_byte;
  assign pop               = out_valid && !out_stall && final_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (out_valid && !out_stall) begin
      idx_r <= final_byte ? 2'd0 : 2'(idx_r + 2'd1);
    end
  end

endmodule

// ----- sv/percent_decoder_unit.sv -----
// Top level of the streaming URL form decoder.
// Decodes application/x-www-form-urlencoded text: '+' becomes a space, '%' with two hex
// digits becomes that byte, a malformed escape is passed on literally and the offending
// byte is decoded afresh, and an escape still open at in_last is flushed as literal bytes.
// One raw byte is accepted per cycle while the bundle queue (QUEUE_DEPTH entries) has room;
// its decoded bytes can leave on the cycle after acceptance. The output side sends one
// decoded byte per cycle while out_stall is low; a raw byte that yields two or three bytes
// holds the output until all are sent, and an escape yields nothing until it completes.
module percent_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pcd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pcd_pkg::out_item_t out_data
);

  logic             push, pop, queue_full;
  pcd_pkg::bundle_t bundle;
  pcd_pkg::head_t   head;

  pcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .queue_full (queue_full),
    .in_stall   (in_stall),
    .push       (push),
    .bundle     (bundle)
  );

  pcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (bundle),
    .pop      (pop),
    .full     (queue_full),
    .head     (head)
  );

  pcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && queue_full))
    else $error("bundle pushed into a full queue");

  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.in_last) |-> push)
    else $error("final raw byte produced no decoded byte");

  a_bundle_fits: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid |-> (head.entry.cnt != 2'd0))
    else $error("queued bundle holds no bytes");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the streaming URL form decoder percent_decoder_unit.
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_PERCENT,
    ESC_DIGIT
  } esc_phase_t;

  typedef struct {
    pcd_pkg::in_item_t item;
    bit                wait_drain;
  } raw_req_t;

  localparam int RAW_TARGET = 305;
  localparam int HOLD_CYCLES = 64;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pcd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pcd_pkg::out_item_t out_data;

  raw_req_t           raw_q[$];
  pcd_pkg::out_item_t decoded_q[$];
  esc_phase_t         esc_phase = ESC_IDLE;
  logic [7:0]         held_digit = 8'h00;
  bit                 drain_next = 1'b0;
  int                 sent_cnt = 0;
  int                 mismatch_cnt = 0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 hold_left = 0;
  int                 holds_done = 0;
  int                 cycle_cnt = 0;

  percent_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    return 5'd16;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_hex();
    string digits;
    digits = "0123456789ABCDEFabcdef";
    return digits[$urandom_range(0, 21)];
  endfunction

  task automatic emit(input logic [7:0] b);
    pcd_pkg::out_item_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    decoded_q.push_back(r);
  endtask

  task automatic decode_fresh(input logic [7:0] b);
    if (b == pcd_pkg::CHAR_PERCENT) begin
      esc_phase = ESC_PERCENT;
    end else if (b == pcd_pkg::CHAR_PLUS) begin
      emit(pcd_pkg::CHAR_SPACE);
    end else begin
      emit(b);
    end
  endtask

  task automatic decode_request(input pcd_pkg::in_item_t req);
    logic [4:0]         v;
    logic [4:0]         hi;
    int                 start_size;
    pcd_pkg::out_item_t tail;
    v = hex_nibble(req.in_byte);
    start_size = decoded_q.size();
    case (esc_phase)
      ESC_PERCENT: begin
        if (!v[4]) begin
          held_digit = req.in_byte;
          esc_phase = ESC_DIGIT;
        end else begin
          esc_phase = ESC_IDLE;
          emit(pcd_pkg::CHAR_PERCENT);
          decode_fresh(req.in_byte);
        end
      end
      ESC_DIGIT: begin
        esc_phase = ESC_IDLE;
        if (!v[4]) begin
          hi = hex_nibble(held_digit);
          emit({hi[3:0], v[3:0]});
        end else begin
          emit(pcd_pkg::CHAR_PERCENT);
          emit(held_digit);
          decode_fresh(req.in_byte);
        end
        held_digit = 8'h00;
      end
      default: begin
        esc_phase = ESC_IDLE;
        decode_fresh(req.in_byte);
      end
    endcase
    if (req.in_last) begin
      if (esc_phase == ESC_PERCENT) begin
        emit(pcd_pkg::CHAR_PERCENT);
      end else if (esc_phase == ESC_DIGIT) begin
        emit(pcd_pkg::CHAR_PERCENT);
        emit(held_digit);
      end
      esc_phase = ESC_IDLE;
      held_digit = 8'h00;
      if (decoded_q.size() > start_size) begin
        tail = decoded_q.pop_back();
        tail.out_last = 1'b1;
        decoded_q.push_back(tail);
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    raw_req_t r;
    r.item.in_byte = b;
    r.item.in_last = 1'b0;
    r.wait_drain = drain_next;
    drain_next = 1'b0;
    raw_q.push_back(r);
  endtask

  task automatic mark_last();
    raw_req_t r;
    r = raw_q.pop_back();
    r.item.in_last = 1'b1;
    raw_q.push_back(r);
  endtask

  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    mark_last();
  endtask

  initial begin
    int len;
    int r;
    add_byte(8'h00);
    add_byte(8'hFF);
    mark_last();
    add_string("%4a");
    add_string("%F+");
    add_string("%%9");
    add_string("%g");
    add_string("%B");
    add_string("%");
    add_string("+");
    add_string("%4%");
    add_string("%7E");
    drain_next = 1'b1;
    while (raw_q.size() < RAW_TARGET) begin
      if (raw_q.size() > 200 && raw_q.size() < 215) drain_next = 1'b1;
      len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          add_byte(8'($urandom_range(0, 255)));
        end else if (r < 52) begin
          add_byte(pcd_pkg::CHAR_PLUS);
        end else if (r < 82) begin
          add_byte(pcd_pkg::CHAR_PERCENT);
          add_byte(rand_hex());
          add_byte(rand_hex());
        end else if (r < 92) begin
          add_byte(pcd_pkg::CHAR_PERCENT);
          add_byte(rand_hex());
          add_byte(8'($urandom_range(0, 255)));
        end else begin
          add_byte(pcd_pkg::CHAR_PERCENT);
          add_byte(8'($urandom_range(0, 255)));
        end
      end
      mark_last();
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (raw_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin : drive_requests
    raw_req_t nxt;
    logic     fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        decode_request(in_data);
        sent_cnt++;
        gap_left = ((sent_cnt / 48) % 3 == 1) ? 0 : pick_gap();
      end
      if (fire || !in_valid) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (raw_q.size() == 0 ||
                     (raw_q[0].wait_drain && decoded_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          nxt = raw_q.pop_front();
          in_valid <= 1'b1;
          in_data <= nxt.item;
        end
      end
    end
  end

  always @(posedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      cycle_cnt++;
      if ((holds_done == 0 && sent_cnt >= 100) || (holds_done == 1 && sent_cnt >= 260)) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ((cycle_cnt / 256) % 4 == 2) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin : check_results
    pcd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: result expected none, got byte %h last %b",
                 $time, out_data.out_byte, out_data.out_last);
        mismatch_cnt++;
      end else begin
        want = decoded_q.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h, got %h",
                   $time, want.out_byte, out_data.out_byte);
          mismatch_cnt++;
        end
        if (out_data.out_last !== want.out_last) begin
          $display("%0t: out_last expected %b, got %b",
                   $time, want.out_last, out_data.out_last);
          mismatch_cnt++;
        end
      end
    end
  end

endmodule

// ----- percent_decoder_unit.f -----
sv/pcd_pkg.sv
sv/pcd_front.sv
sv/pcd_fifo.sv
sv/pcd_back.sv
sv/percent_decoder_unit.sv
verif/testbench.sv
